FILE: rtl/carl_pkg.sv
// ----------------------------------------------------------------------------
// carl_pkg
// Shared types and codes of the coalescing activity ring log: the stored
// entry layout, event codes, sequencer states and memory control.
// ----------------------------------------------------------------------------
package carl_pkg;

  localparam int unsigned FREQ_W     = 32;
  localparam int unsigned TIME_W     = 16;
  localparam int unsigned STRENGTH_W = 8;
  localparam int unsigned WINDOW_W   = 16;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned INDEX_W    = 4;
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned COUNT_W    = 5;
  localparam int unsigned UPTIME_W   = 32;
  localparam int unsigned RSSI_W     = 9;

  // Time stamp is uptime bits 22..7, strength is rssi bits 8..1.
  localparam int unsigned TIME_LSB     = 7;
  localparam int unsigned STRENGTH_LSB = 1;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd8;

  typedef enum logic [OP_W-1:0] {
    OP_RECORD = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_READ   = 2'd2
  } op_e;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic [FREQ_W-1:0]     freq;
    logic [TIME_W-1:0]     stamp;
    logic [STRENGTH_W-1:0] strength;
    logic                  chan;
  } entry_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr;
  } mem_ctl_t;

endpackage

FILE: rtl/coalescing_activity_ring_log_core.sv
// ----------------------------------------------------------------------------
// coalescing_activity_ring_log_core
// Ring log of radio activity: a record merges into the head entry when the
// frequency matches and the time gap is within the window, else appends.
// ----------------------------------------------------------------------------
// Sequence: an accepted event starts a read-modify-write of one entry through
//   the registered store read: read in idle, then update and result register
//   in EXEC, held while the previous result stalls; no new event meanwhile.
// Reset: head, count, window (to 8) and all slot valid bits clear at once;
//   the log reads as all zero immediately, no clearing pass.
module coalescing_activity_ring_log_core #(
  parameter int unsigned LOG_DEPTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [carl_pkg::WINDOW_W-1:0]        cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [carl_pkg::OP_W-1:0]            op_i,
  input  logic [carl_pkg::FREQ_W-1:0]          freq_or_chan_i,
  input  logic                                 is_channel_i,
  input  logic [carl_pkg::UPTIME_W-1:0]        uptime_raw_i,
  input  logic [carl_pkg::RSSI_W-1:0]          rssi_raw_i,
  input  logic [carl_pkg::INDEX_W-1:0]         read_index_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 merged_o,
  output logic [carl_pkg::SLOT_W-1:0]          head_slot_o,
  output logic [carl_pkg::COUNT_W-1:0]         entry_count_o,
  output logic [carl_pkg::FREQ_W-1:0]          out_freq_o,
  output logic [carl_pkg::TIME_W-1:0]          out_time_o,
  output logic [carl_pkg::STRENGTH_W-1:0]      out_strength_o,
  output logic                                 out_channel_flag_o
);
  import carl_pkg::*;

  localparam int unsigned AW = $clog2(LOG_DEPTH);
  localparam int unsigned CW = $clog2(LOG_DEPTH + 1);
  localparam int unsigned XW = AW + INDEX_W;

  state_e                  state_q, state_d;
  logic                    accept;
  logic                    exec_go;

  logic [WINDOW_W-1:0]     window_q;
  logic [AW-1:0]           head_q, head_d;
  logic [CW-1:0]           count_q, count_d;

  // Transaction fields held for the update cycle
  logic [OP_W-1:0]         op_q;
  logic [FREQ_W-1:0]       freq_q;
  logic                    chan_q;
  logic [TIME_W-1:0]       now_q;
  logic [STRENGTH_W-1:0]   rssi_q;
  logic                    idx_ok_q;

  logic [XW-1:0]           idx_ext;
  logic [AW-1:0]           rd_addr;
  logic [AW-1:0]           wr_addr;
  mem_ctl_t                mem_ctl;
  entry_t                  rd_entry;
  entry_t                  wr_entry;

  logic [TIME_W-1:0]       gap;
  logic                    merge;
  logic [AW-1:0]           head_inc;
  entry_t                  res_entry;
  logic                    res_merged;

  logic                    out_valid_q;
  logic                    out_merged_q;
  logic [AW-1:0]           out_head_q;
  logic [CW-1:0]           out_count_q;
  entry_t                  out_entry_q;
  logic [AW+SLOT_W-1:0]    head_ext;
  logic [CW+COUNT_W-1:0]   count_ext;

  // -------------------------------------------------------------------------
  // Sequencer
  // -------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_go) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    exec_go    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
      end
      ST_EXEC: begin
        // hold while the previous result is still stalled
        exec_go = !(out_valid_q && out_stall_i);
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  assign accept = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // -------------------------------------------------------------------------
  // Configuration
  // -------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WINDOW_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      window_q <= cfg_data_i;
    end
  end

  // -------------------------------------------------------------------------
  // Capture and store read
  // -------------------------------------------------------------------------
  assign idx_ext = {{AW{1'b0}}, read_index_i};
  assign rd_addr = (op_i == OP_RECORD) ? head_q : idx_ext[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= op_i;
      freq_q   <= freq_or_chan_i;
      chan_q   <= is_channel_i;
      now_q    <= uptime_raw_i[TIME_LSB +: TIME_W];
      rssi_q   <= rssi_raw_i[STRENGTH_LSB +: STRENGTH_W];
      idx_ok_q <= (idx_ext < XW'(LOG_DEPTH));
    end
  end

  // -------------------------------------------------------------------------
  // Update
  // -------------------------------------------------------------------------
  assign gap      = now_q - rd_entry.stamp;
  assign merge    = (count_q != '0) && (rd_entry.freq == freq_q) && (gap <= window_q);
  assign head_inc = (head_q == AW'(LOG_DEPTH - 1)) ? '0 : head_q + 1'b1;

  always_comb begin
    head_d        = head_q;
    count_d       = count_q;
    res_entry     = '0;
    res_merged    = 1'b0;
    wr_entry      = '0;
    wr_addr       = head_q;
    mem_ctl.rd_en = accept;
    mem_ctl.wr_en = 1'b0;
    mem_ctl.clr   = 1'b0;
    case (op_q)
      OP_RECORD: begin
        mem_ctl.wr_en = exec_go;
        if (merge) begin
          res_merged     = 1'b1;
          wr_entry       = rd_entry;
          wr_entry.stamp = now_q;
          if (rssi_q > rd_entry.strength) begin
            wr_entry.strength = rssi_q;
          end
        end else begin
          head_d            = head_inc;
          wr_addr           = head_inc;
          wr_entry.freq     = freq_q;
          wr_entry.stamp    = now_q;
          wr_entry.strength = rssi_q;
          wr_entry.chan     = chan_q;
          if (count_q != CW'(LOG_DEPTH)) begin
            count_d = count_q + 1'b1;
          end
        end
        res_entry = wr_entry;
      end
      OP_CLEAR: begin
        mem_ctl.clr = exec_go;
        head_d      = '0;
        count_d     = '0;
      end
      OP_READ: begin
        if (idx_ok_q) begin
          res_entry = rd_entry;
        end
      end
      default: begin
        res_entry = '0;
      end
    endcase
  end

  carl_entry_mem #(
    .LOG_DEPTH (LOG_DEPTH),
    .AW        (AW)
  ) u_entry_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (mem_ctl),
    .rd_addr_i  (rd_addr),
    .wr_addr_i  (wr_addr),
    .wr_entry_i (wr_entry),
    .rd_entry_o (rd_entry)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else if (exec_go) begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  // -------------------------------------------------------------------------
  // Result register
  // -------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec_go) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_go) begin
      out_merged_q <= res_merged;
      out_head_q   <= head_d;
      out_count_q  <= count_d;
      out_entry_q  <= res_entry;
    end
  end

  assign head_ext  = {{SLOT_W{1'b0}}, out_head_q};
  assign count_ext = {{COUNT_W{1'b0}}, out_count_q};

  assign out_valid_o        = out_valid_q;
  assign merged_o           = out_merged_q;
  assign head_slot_o        = head_ext[SLOT_W-1:0];
  assign entry_count_o      = count_ext[COUNT_W-1:0];
  assign out_freq_o         = out_entry_q.freq;
  assign out_time_o         = out_entry_q.stamp;
  assign out_strength_o     = out_entry_q.strength;
  assign out_channel_flag_o = out_entry_q.chan;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(LOG_DEPTH))
    else $error("entry count above depth");

  a_head_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= AW'(LOG_DEPTH - 1))
    else $error("head pointer outside ring");

  a_empty_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == '0 |-> head_q == '0)
    else $error("empty log with nonzero head");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_EXEC)
    else $error("accepted transaction not executed");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC && out_valid_q && out_stall_i) |=>
      (state_q == ST_EXEC && $stable(head_q) && $stable(count_q)))
    else $error("update ran over a stalled result");
`endif

endmodule

FILE: rtl/carl_entry_mem.sv
// ----------------------------------------------------------------------------
// carl_entry_mem
// Entry store of the ring log: one synchronous memory with a registered read
// port and one valid bit per slot; slots that are not valid read as zero.
// ----------------------------------------------------------------------------
module carl_entry_mem #(
  parameter int unsigned LOG_DEPTH = 16,
  parameter int unsigned AW        = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  carl_pkg::mem_ctl_t ctl_i,
  input  logic [AW-1:0]     rd_addr_i,
  input  logic [AW-1:0]     wr_addr_i,
  input  carl_pkg::entry_t  wr_entry_i,
  output carl_pkg::entry_t  rd_entry_o
);
  import carl_pkg::*;

  entry_t                 mem [LOG_DEPTH];
  entry_t                 rdata_q;
  logic                   rvalid_q;
  logic [LOG_DEPTH-1:0]   valid_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[wr_addr_i] <= wr_entry_i;
    end
    if (ctl_i.rd_en) begin
      rdata_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (ctl_i.clr) begin
        valid_q <= '0;
      end else if (ctl_i.wr_en) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (ctl_i.rd_en) begin
        rvalid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_entry_o = rvalid_q ? rdata_q : '0;

endmodule
